FILE: rtl/assert_macros.svh
// Assertion macros used by the LED flash controller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/lfc_pkg.sv
// Types and constants shared by the LED flash controller modules.
`timescale 1ns / 1ps
package lfc_pkg;

    localparam int unsigned MS_PER_SECOND   = 1000;
    localparam int unsigned STARTUP_SECONDS = 5;

    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned SCALED_W  = 33;
    // Scaled time counter saturates here; every duration product is below it.
    localparam logic [SCALED_W-1:0] SCALED_CAP = {1'b1, {(SCALED_W-1){1'b0}}};

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_STEADY = 2'd1;
    localparam logic [1:0] ACT_FLASH  = 2'd2;

    typedef enum logic [5:0] {
        PH_HOME      = 6'b000001,
        PH_STARTUP   = 6'b000010,
        PH_STEADY    = 6'b000100,
        PH_FSTART    = 6'b001000,
        PH_WAIT_LIT  = 6'b010000,
        PH_WAIT_DARK = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        level;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [15:0] flash_count;
    } item_t;

    typedef struct packed {
        logic        led_lit;
        logic        flashing;
        logic [15:0] flashes_left;
    } result_t;

endpackage

FILE: rtl/lfc_scale.sv
// Tick-rate register and duration products (ticks_per_second * ms).
`timescale 1ns / 1ps
module lfc_scale
    import lfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic [15:0] on_dur_next,
    input  logic [15:0] off_dur_next,
    output logic [15:0] tps,
    output logic [31:0] on_prod,
    output logic [31:0] off_prod
);

    logic [15:0] tps_reg;
    logic [15:0] tps_next;
    logic [31:0] on_prod_reg;
    logic [31:0] on_prod_next;
    logic [31:0] off_prod_reg;
    logic [31:0] off_prod_next;

    // Products track the values the registers will hold after this edge,
    // so they always match the current rate and durations.
    assign tps_next      = cfg_wr_en ? cfg_wr_data : tps_reg;
    assign on_prod_next  = 32'(tps_next) * 32'(on_dur_next);
    assign off_prod_next = 32'(tps_next) * 32'(off_dur_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg      <= 16'(MS_PER_SECOND);
            on_prod_reg  <= '0;
            off_prod_reg <= '0;
        end else begin
            tps_reg      <= tps_next;
            on_prod_reg  <= on_prod_next;
            off_prod_reg <= off_prod_next;
        end
    end

    assign tps      = tps_reg;
    assign on_prod  = on_prod_reg;
    assign off_prod = off_prod_reg;

endmodule

FILE: rtl/lfc_fsm.sv
// Flash state machine: state registers and per-beat next-state logic.
`timescale 1ns / 1ps
module lfc_fsm
    import lfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  item_t       item,
    input  logic [15:0] tps,
    input  logic [31:0] on_prod,
    input  logic [31:0] off_prod,
    output logic [15:0] on_dur_next,
    output logic [15:0] off_dur_next,
    output result_t     result
);

    phase_t                phase_reg, phase_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [SCALED_W-1:0]   scaled_reg, scaled_next;
    logic                  flash_mode_reg, flash_mode_next;
    logic                  steady_level_reg, steady_level_next;
    logic [15:0]           on_dur_reg;
    logic [15:0]           off_dur_reg;
    logic [15:0]           count_reg, count_next;
    logic                  lit_reg, lit_next;

    logic [ELAPSED_W-1:0]  elapsed_inc;
    logic [SCALED_W-1:0]   scaled_sum;
    logic [SCALED_W-1:0]   scaled_inc;
    logic [18:0]           startup_lim;
    logic                  on_done;
    logic                  off_done;
    logic                  last_flash;

    // scaled tracks min(1000 * (elapsed + 1), cap): duration reached when
    // tps * ms < 1000 * (elapsed + 1), which avoids a divider.
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + ELAPSED_W'(1);
    assign scaled_sum  = scaled_reg + SCALED_W'(MS_PER_SECOND);
    assign scaled_inc  = (scaled_sum > SCALED_CAP) ? SCALED_CAP : scaled_sum;
    assign startup_lim = {1'b0, tps, 2'b00} + {3'b000, tps};
    assign on_done     = {1'b0, on_prod} < scaled_inc;
    assign off_done    = {1'b0, off_prod} < scaled_inc;
    assign last_flash  = (count_reg == 16'd1);

    always_comb begin
        phase_next        = phase_reg;
        elapsed_next      = elapsed_reg;
        scaled_next       = scaled_reg;
        flash_mode_next   = flash_mode_reg;
        steady_level_next = steady_level_reg;
        on_dur_next       = on_dur_reg;
        off_dur_next      = off_dur_reg;
        count_next        = count_reg;
        lit_next          = lit_reg;
        if (fire) begin
            unique case (item.action)
                ACT_TICK: begin
                    elapsed_next = elapsed_inc;
                    scaled_next  = scaled_inc;
                    unique case (phase_reg)
                        PH_HOME: begin
                            elapsed_next = '0;
                            scaled_next  = SCALED_W'(MS_PER_SECOND);
                            phase_next   = PH_STARTUP;
                        end
                        PH_STARTUP: begin
                            if (elapsed_inc >= ELAPSED_W'(startup_lim)) begin
                                phase_next = PH_STEADY;
                            end
                        end
                        PH_STEADY: begin
                            if (flash_mode_reg) begin
                                phase_next = PH_FSTART;
                            end
                            lit_next = steady_level_reg;
                        end
                        PH_FSTART: begin
                            lit_next     = 1'b1;
                            elapsed_next = '0;
                            scaled_next  = SCALED_W'(MS_PER_SECOND);
                            phase_next   = PH_WAIT_LIT;
                        end
                        PH_WAIT_LIT: begin
                            if (!flash_mode_reg) begin
                                phase_next = PH_STEADY;
                            end else if (on_done) begin
                                lit_next = 1'b0;
                                if (count_reg != '0) begin
                                    count_next = count_reg - 16'd1;
                                end
                                if (last_flash) begin
                                    // count ran out: back to steady off
                                    flash_mode_next   = 1'b0;
                                    steady_level_next = 1'b0;
                                    phase_next        = PH_STEADY;
                                end else begin
                                    elapsed_next = '0;
                                    scaled_next  = SCALED_W'(MS_PER_SECOND);
                                    phase_next   = PH_WAIT_DARK;
                                end
                            end
                        end
                        PH_WAIT_DARK: begin
                            if (!flash_mode_reg) begin
                                phase_next = PH_STEADY;
                            end else if (off_done) begin
                                lit_next     = 1'b1;
                                elapsed_next = '0;
                                scaled_next  = SCALED_W'(MS_PER_SECOND);
                                phase_next   = PH_WAIT_LIT;
                            end
                        end
                        default: begin
                            phase_next = PH_HOME;
                        end
                    endcase
                end
                ACT_STEADY: begin
                    flash_mode_next   = 1'b0;
                    steady_level_next = item.level;
                end
                ACT_FLASH: begin
                    flash_mode_next = 1'b1;
                    on_dur_next     = item.on_ms;
                    off_dur_next    = item.off_ms;
                    count_next      = item.flash_count;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HOME;
            elapsed_reg      <= '0;
            scaled_reg       <= SCALED_W'(MS_PER_SECOND);
            flash_mode_reg   <= 1'b0;
            steady_level_reg <= 1'b0;
            on_dur_reg       <= '0;
            off_dur_reg      <= '0;
            count_reg        <= '0;
            lit_reg          <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            elapsed_reg      <= elapsed_next;
            scaled_reg       <= scaled_next;
            flash_mode_reg   <= flash_mode_next;
            steady_level_reg <= steady_level_next;
            on_dur_reg       <= on_dur_next;
            off_dur_reg      <= off_dur_next;
            count_reg        <= count_next;
            lit_reg          <= lit_next;
        end
    end

    assign result.led_lit      = lit_next;
    assign result.flashing     = flash_mode_next;
    assign result.flashes_left = flash_mode_next ? count_next : 16'd0;

endmodule

FILE: rtl/led_flash_controller.sv
// Top level of the status LED flash controller.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//  - s_ channel: one beat per tick or command. s_tuser carries the action
//    (tick, set steady level, start flashing); s_tdata carries its operands.
//  - m_ channel: exactly one result beat per input beat, in order, showing
//    LED drive, flash mode and flashes left after that beat was applied.
//  - cfg_wr_en / cfg_wr_data write ticks_per_second (reset 1000); write it
//    only while no beats are in flight.
//  - Path: a taken beat is held in the input register, then the state update
//    writes its result into the result register, which drives m_.
//  - Throughput: one beat per cycle unless m_ stalls; the state update is a
//    single step and duration products are kept registered, so nothing
//    loops.
//  - Reset (aresetn low, synchronous) clears all state; the LED is held off
//    for five seconds of ticks before steady/flash behavior starts.
//  - Receiver stall: the result register holds; one more beat is held in
//    the input register, after which s_tready drops until m_tready returns.
module led_flash_controller
    import lfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config: ticks_per_second
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic [55:0] s_tdata,   // [0] level, [16:1] on_ms, [32:17] off_ms,
                                   // [48:33] flash_count, [55:49] zero
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] led_lit, [1] flashing,
                                   // [17:2] flashes_left, [23:18] zero
);

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_result_reg;

    logic        s_accept;
    logic        out_free;
    logic        fire;
    item_t       s_item;
    result_t     result;
    logic [15:0] tps;
    logic [31:0] on_prod;
    logic [31:0] off_prod;
    logic [15:0] on_dur_next;
    logic [15:0] off_dur_next;

    assign s_item.action      = s_tuser;
    assign s_item.level       = s_tdata[0];
    assign s_item.on_ms       = s_tdata[16:1];
    assign s_item.off_ms      = s_tdata[32:17];
    assign s_item.flash_count = s_tdata[48:33];

    // beat moves from the input register into the state/result stage
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (fire) begin
            out_result_reg <= result;
        end
    end

    lfc_scale u_scale (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .on_dur_next  (on_dur_next),
        .off_dur_next (off_dur_next),
        .tps          (tps),
        .on_prod      (on_prod),
        .off_prod     (off_prod)
    );

    lfc_fsm u_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .item         (in_item_reg),
        .tps          (tps),
        .on_prod      (on_prod),
        .off_prod     (off_prod),
        .on_dur_next  (on_dur_next),
        .off_dur_next (off_dur_next),
        .result       (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_result_reg.flashes_left,
                       out_result_reg.flashing, out_result_reg.led_lit};

    `ASSERT_NEXT(a_fire_gives_beat, aclk, aresetn, fire, m_tvalid,
                 "result beat missing after fire")
    `ASSERT_ALWAYS(a_stall_only_when_full, aclk, aresetn,
                   !s_tready |-> (in_valid_reg && m_tvalid && !m_tready),
                   "input stalled with room left")
    `ASSERT_ALWAYS(a_count_zero_steady, aclk, aresetn,
                   (m_tvalid && !m_tdata[1]) |-> (m_tdata[17:2] == 16'd0),
                   "flashes left shown in steady mode")

endmodule

FILE: verif/tb_led_flash_controller.sv
// Self-checking testbench for the LED flash controller: tick/command beats in, state beats out.
`timescale 1ns / 1ps
module tb_led_flash_controller;
    import lfc_pkg::*;

    // the one action code the package leaves unnamed; the block ignores it
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned BEATS_PER_PHASE = 140;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    led_flash_controller i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // LED state predictor (reset values set once, reset is never repeated)
    // ---------------------------------------------------------------
    logic [15:0] tick_rate = 16'd1000;
    phase_t      led_phase = PH_HOME;
    logic [31:0] led_elapsed = '0;
    logic        flash_on = 1'b0;
    logic        hold_level = 1'b0;
    logic [15:0] lit_ms = '0;
    logic [15:0] dark_ms = '0;
    logic [15:0] flashes_togo = '0;
    logic        led_now = 1'b0;

    item_t   beat_q[$];
    result_t led_expect_q[$];

    bit          idle_on = 1'b1;
    int unsigned err_count = 0;
    int unsigned result_seen = 0;
    int unsigned cycle_count = 0;

    function automatic logic [31:0] ms_in_ticks(logic [15:0] ms);
        logic [31:0] prod;
        prod = 32'(tick_rate) * 32'(ms);
        return prod / MS_PER_SECOND;
    endfunction

    // one state-machine step, run on each tick beat
    function automatic void led_tick();
        if (led_elapsed != '1) led_elapsed++;
        case (led_phase)
            PH_HOME: begin
                led_elapsed = '0;
                led_phase = PH_STARTUP;
            end
            PH_STARTUP: begin
                if (led_elapsed >= STARTUP_SECONDS * tick_rate) led_phase = PH_STEADY;
            end
            PH_STEADY: begin
                if (flash_on) led_phase = PH_FSTART;
                led_now = hold_level;
            end
            PH_FSTART: begin
                led_now = 1'b1;
                led_elapsed = '0;
                led_phase = PH_WAIT_LIT;
            end
            PH_WAIT_LIT: begin
                if (!flash_on) begin
                    led_phase = PH_STEADY;
                end else if (led_elapsed >= ms_in_ticks(lit_ms)) begin
                    led_now = 1'b0;
                    if (flashes_togo == 0) begin
                        led_elapsed = '0;
                        led_phase = PH_WAIT_DARK;
                    end else begin
                        flashes_togo--;
                        // a finite count that just hit zero falls back to steady off
                        if (flashes_togo == 0) begin
                            flash_on = 1'b0;
                            hold_level = 1'b0;
                            led_phase = PH_STEADY;
                        end else begin
                            led_elapsed = '0;
                            led_phase = PH_WAIT_DARK;
                        end
                    end
                end
            end
            PH_WAIT_DARK: begin
                if (!flash_on) begin
                    led_phase = PH_STEADY;
                end else if (led_elapsed >= ms_in_ticks(dark_ms)) begin
                    led_now = 1'b1;
                    led_elapsed = '0;
                    led_phase = PH_WAIT_LIT;
                end
            end
            default: led_phase = PH_HOME;
        endcase
    endfunction

    function automatic result_t led_apply(item_t it);
        result_t r;
        case (it.action)
            ACT_TICK: begin
                led_tick();
            end
            ACT_STEADY: begin
                flash_on = 1'b0;
                hold_level = it.level;
            end
            ACT_FLASH: begin
                flash_on = 1'b1;
                lit_ms = it.on_ms;
                dark_ms = it.off_ms;
                flashes_togo = it.flash_count;
            end
            default: ;
        endcase
        r.led_lit = led_now;
        r.flashing = flash_on;
        r.flashes_left = flash_on ? flashes_togo : '0;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // idle shaping: mostly short gaps, a few long ones, none when idle_on is low
    // ---------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // driver: pops pending beats, predicts on each accepted beat
    // ---------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge aclk) begin : drive_proc
        item_t taken;
        item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.action = s_tuser;
                taken.level = s_tdata[0];
                taken.on_ms = s_tdata[16:1];
                taken.off_ms = s_tdata[32:17];
                taken.flash_count = s_tdata[48:33];
                led_expect_q.push_back(led_apply(taken));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (beat_q.size() != 0) begin
                    nxt = beat_q.pop_front();
                    s_tuser <= nxt.action;
                    s_tdata <= {7'd0, nxt.flash_count, nxt.off_ms, nxt.on_ms, nxt.level};
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random back-pressure and field-by-field compare
    // ---------------------------------------------------------------
    int unsigned stall_left = 0;

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < 100)
            $display("mismatch on result %0d: %s got %0h want %0h", result_seen, what, got,
                     want);
        err_count++;
    endtask

    always @(posedge aclk) begin : watch_proc
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (led_expect_q.size() == 0) begin
                    flag_mismatch("beat with nothing expected", 32'(m_tdata), 0);
                end else begin
                    want = led_expect_q.pop_front();
                    if (m_tdata[0] !== want.led_lit)
                        flag_mismatch("led_lit", 32'(m_tdata[0]), 32'(want.led_lit));
                    if (m_tdata[1] !== want.flashing)
                        flag_mismatch("flashing", 32'(m_tdata[1]), 32'(want.flashing));
                    if (m_tdata[17:2] !== want.flashes_left)
                        flag_mismatch("flashes_left", 32'(m_tdata[17:2]),
                                      32'(want.flashes_left));
                end
                result_seen++;
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic push_ticks(int unsigned n);
        item_t it;
        repeat (n) begin
            it.action = ACT_TICK;
            it.level = 1'($urandom);
            it.on_ms = 16'($urandom);
            it.off_ms = 16'($urandom);
            it.flash_count = 16'($urandom);
            beat_q.push_back(it);
        end
    endtask

    task automatic push_cmd(logic [1:0] act, logic lvl, logic [15:0] on_t, logic [15:0] off_t,
                            logic [15:0] cnt);
        item_t it;
        it.action = act;
        it.level = lvl;
        it.on_ms = on_t;
        it.off_ms = off_t;
        it.flash_count = cnt;
        beat_q.push_back(it);
    endtask

    task automatic drain_all();
        while (beat_q.size() != 0 || s_tvalid || led_expect_q.size() != 0) @(posedge aclk);
    endtask

    // register writes only with nothing in flight
    task automatic set_tick_rate(logic [15:0] v);
        drain_all();
        repeat (3) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        tick_rate = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // command followed by a run of ticks; durations kept to a few ticks,
    // with an occasional full-range command as noise
    task automatic random_phase(int unsigned n_beats);
        int unsigned pushed;
        int unsigned r;
        int unsigned run;
        logic [15:0] ms_cap;
        pushed = 0;
        ms_cap = (tick_rate == 0) ? 16'hFFFF : 16'(4000 / tick_rate + 1);
        while (pushed < n_beats) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if ($urandom_range(0, 9) == 0)
                    push_cmd(ACT_FLASH, 1'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
                else
                    push_cmd(ACT_FLASH, 1'($urandom), 16'($urandom_range(0, ms_cap)),
                             16'($urandom_range(0, ms_cap)),
                             ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
            end else if (r < 92) begin
                push_cmd(ACT_STEADY, 1'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end else begin
                push_cmd(ACT_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end
            run = $urandom_range(0, 25);
            push_ticks(run);
            pushed += run + 1;
        end
    endtask

    logic [15:0] rate_plan[7];

    initial begin
        rate_plan = '{16'd1, 16'd0, 16'd1000, 16'd65535, 16'd3, 16'd250, 16'd1};
        rate_plan[6] = 16'($urandom_range(1, 65535));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // one tick per second keeps the start-up wait to five ticks
        set_tick_rate(16'd1);
        push_ticks(1);
        push_cmd(ACT_STEADY, 1'b1, 16'd0, 16'd0, 16'd0);   // level set during start-up
        push_ticks(6);
        push_cmd(ACT_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(ACT_FLASH, 1'b0, 16'd1000, 16'd2000, 16'd2);  // count runs out
        push_ticks(6);
        push_cmd(ACT_FLASH, 1'b0, 16'd0, 16'd0, 16'd0);        // zero times, endless
        push_ticks(3);
        push_cmd(ACT_FLASH, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF); // retarget while flashing
        push_ticks(1);
        push_cmd(ACT_STEADY, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF); // leave flash mid-wait
        push_ticks(1);
        push_cmd(ACT_STEADY, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_ticks(1);

        for (int p = 0; p < 7; p++) begin
            idle_on = (p % 2 == 0);
            set_tick_rate(rate_plan[p]);
            random_phase(BEATS_PER_PHASE);
        end

        drain_all();
        repeat (4) @(posedge aclk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
